// ===== rtl/tcbc_pkg.sv =====
// Shared types, register map and constants for the chained TEA cipher.
// No dependencies; imported by every module of the block.
package tcbc_pkg;

  localparam int ADDR_W = 5;
  localparam int RC_W   = 7;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_KEY0   = 3'd0;
  localparam logic [2:0] REG_KEY1   = 3'd1;
  localparam logic [2:0] REG_KEY2   = 3'd2;
  localparam logic [2:0] REG_KEY3   = 3'd3;
  localparam logic [2:0] REG_DELTA  = 3'd4;
  localparam logic [2:0] REG_ROUNDS = 3'd5;
  localparam logic [2:0] REG_CHAIN  = 3'd6;

  localparam logic [31:0]     RESET_DELTA  = 32'h9E3779B9;
  localparam logic [RC_W-1:0] RESET_ROUNDS = 7'd16;
  localparam logic [RC_W-1:0] MAX_ROUNDS   = 7'd64;

  typedef struct packed {
    logic [31:0]     key0;
    logic [31:0]     key1;
    logic [31:0]     key2;
    logic [31:0]     key3;
    logic [31:0]     delta;
    logic [RC_W-1:0] rounds;
    logic            chain;
  } cfg_t;

  typedef struct packed {
    logic load;    // capture the input beat
    logic step;    // run one half round
    logic half;    // 0: first half of the round, 1: second half
    logic finish;  // emit the result and update the chain state
  } ctrl_cmd_t;

  typedef struct packed {
    logic [RC_W-1:0] rounds;
    logic            out_free;
  } ctrl_stat_t;

  // clamp the programmed round count to the supported maximum
  function automatic logic [RC_W-1:0] eff_rounds(input logic [RC_W-1:0] rc);
    return (rc > MAX_ROUNDS) ? MAX_ROUNDS : rc;
  endfunction

endpackage

// ===== rtl/tcbc_ctrl.sv =====
// Sequencer for the chained TEA cipher: accept, round loop, result handoff.
// Depends on tcbc_pkg.
module tcbc_ctrl import tcbc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]      state, state_next;
  logic [RC_W-1:0] cnt, cnt_next;
  logic            half, half_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    half_next  = half;
    cmd        = '0;
    cmd.half   = half;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = stat.rounds;
          half_next  = 1'b0;
          state_next = (stat.rounds == '0) ? S_DONE : S_RUN;
        end
      end
      S_RUN: begin
        cmd.step  = 1'b1;
        half_next = ~half;
        if (half) begin
          cnt_next = cnt - 1'b1;
          if (cnt == {{(RC_W-1){1'b0}}, 1'b1}) begin
            state_next = S_DONE;
          end
        end
      end
      S_DONE: begin
        // hold until the output register can take the beat
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      half  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      half  <= half_next;
    end
  end

endmodule

// ===== rtl/tcbc_datapath.sv =====
// Datapath for the chained TEA cipher: block words, round sum, chain state.
// One half round per step command. Depends on tcbc_pkg.
module tcbc_datapath import tcbc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  ctrl_cmd_t   cmd,
  input  cfg_t        cfg,
  input  logic        func,
  input  logic        first_block,
  input  logic [31:0] word_a,
  input  logic [31:0] word_b,
  output logic [63:0] res
);

  logic [31:0] a, b, sum;
  logic        dec;
  logic [63:0] keep;        // encrypt: inner value, decrypt: raw ciphertext
  logic [63:0] last_cipher;
  logic [63:0] last_inner;

  logic [63:0] blk, chain_c, chain_i, enc_in, dec_in, core;
  logic [31:0] dec_sum;
  logic        sel_a;
  logic [31:0] v, ka, kb, m, tgt, upd;

  function automatic logic [31:0] mix(input logic [31:0] x, input logic [31:0] s,
                                      input logic [31:0] k_lo, input logic [31:0] k_hi);
    return ((x << 4) + k_lo) ^ (x + s) ^ ((x >> 5) + k_hi);
  endfunction

  assign blk     = {word_a, word_b};
  assign chain_c = first_block ? 64'd0 : last_cipher;
  assign chain_i = first_block ? 64'd0 : last_inner;
  assign enc_in  = cfg.chain ? (blk ^ chain_c) : blk;
  assign dec_in  = cfg.chain ? (blk ^ chain_i) : blk;
  assign dec_sum = 32'(cfg.delta * {25'd0, eff_rounds(cfg.rounds)});

  // one mix unit serves both halves of the round
  assign sel_a = dec ? ~cmd.half : cmd.half;
  assign v     = sel_a ? a : b;
  assign ka    = sel_a ? cfg.key2 : cfg.key0;
  assign kb    = sel_a ? cfg.key3 : cfg.key1;
  assign m     = mix(v, sum, ka, kb);
  assign tgt   = sel_a ? b : a;
  assign upd   = dec ? (tgt - m) : (tgt + m);

  assign core = {a, b};
  always_comb begin
    if (!cfg.chain) begin
      res = core;
    end else if (dec) begin
      res = core ^ last_cipher;
    end else begin
      res = core ^ last_inner;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dec <= func;
      if (func) begin
        {a, b} <= dec_in;
        keep   <= blk;
        sum    <= dec_sum;
      end else begin
        {a, b} <= enc_in;
        keep   <= enc_in;
        sum    <= cfg.delta;
      end
    end else if (cmd.step) begin
      if (sel_a) begin
        b <= upd;
      end else begin
        a <= upd;
      end
      if (cmd.half) begin
        sum <= dec ? (sum - cfg.delta) : (sum + cfg.delta);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_cipher <= '0;
      last_inner  <= '0;
    end else if (cmd.load && first_block) begin
      last_cipher <= '0;
      last_inner  <= '0;
    end else if (cmd.finish && cfg.chain) begin
      if (dec) begin
        last_inner  <= core;
        last_cipher <= keep;
      end else begin
        last_inner  <= keep;
        last_cipher <= res;
      end
    end
  end

endmodule

// ===== rtl/tea_chained_block_cipher.sv =====
// TEA block cipher with xor chaining; one 64-bit block per beat.
// N = min(round_count, 64) rounds are run per block; a block with N = 0 goes straight
// to the result handoff. One block at a time: the next beat is taken once the previous
// result is handed to the output register, as the shared mix unit does one half
// round per cycle. rst is synchronous: registers return to their reset values and the
// chain state clears to zero.
module tea_chained_block_cipher import tcbc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // input block channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              func,
  input  logic              first_block,
  input  logic [31:0]       word_a,
  input  logic [31:0]       word_b,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_a,
  output logic [31:0]       out_b,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;
  logic [63:0] res;
  logic [2:0]  reg_idx;
  logic        reg_wr;

  // ------------------------------------------------------------------
  // Configuration registers: written on the access phase of a write,
  // addresses beyond the map are dropped and read back as zero.
  // ------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign reg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key0   <= '0;
      cfg.key1   <= '0;
      cfg.key2   <= '0;
      cfg.key3   <= '0;
      cfg.delta  <= RESET_DELTA;
      cfg.rounds <= RESET_ROUNDS;
      cfg.chain  <= 1'b1;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_KEY0:   cfg.key0   <= pwdata;
        REG_KEY1:   cfg.key1   <= pwdata;
        REG_KEY2:   cfg.key2   <= pwdata;
        REG_KEY3:   cfg.key3   <= pwdata;
        REG_DELTA:  cfg.delta  <= pwdata;
        REG_ROUNDS: cfg.rounds <= pwdata[RC_W-1:0];
        REG_CHAIN:  cfg.chain  <= pwdata[0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_KEY0:   prdata = cfg.key0;
      REG_KEY1:   prdata = cfg.key1;
      REG_KEY2:   prdata = cfg.key2;
      REG_KEY3:   prdata = cfg.key3;
      REG_DELTA:  prdata = cfg.delta;
      REG_ROUNDS: prdata = {{(32-RC_W){1'b0}}, cfg.rounds};
      REG_CHAIN:  prdata = {31'd0, cfg.chain};
      default:    prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // Sequencer and datapath. The sequencer sees the clamped round count
  // and whether the output register can take a new beat.
  // ------------------------------------------------------------------
  assign stat.rounds   = eff_rounds(cfg.rounds);
  assign stat.out_free = ~out_valid | out_ready;

  tcbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcbc_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg         (cfg),
    .func        (func),
    .first_block (first_block),
    .word_a      (word_a),
    .word_b      (word_b),
    .res         (res)
  );

  // ------------------------------------------------------------------
  // Output register: decouples the round loop from the consumer so the
  // next block can be taken while a result beat still waits.
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_a <= res[63:32];
      out_b <= res[31:0];
    end
  end

  // ------------------------------------------------------------------
  // Checks
  // ------------------------------------------------------------------
  // a result is only handed over when the output register is free
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("result written over a pending output beat");

  // load, step and finish never overlap
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.step, cmd.finish}))
    else $error("overlapping sequencer commands");

  // after an accept the block is busy with that item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("new beat taken while an item is in flight");

endmodule
